/* sv/work_stealing_task_deque_bank_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the task deque bank
// Shared clocking and reset disable for the concurrent checks.
// ----------------------------------------------------------------------------
`ifndef WORK_STEALING_TASK_DEQUE_BANK_DEFINES_SVH
`define WORK_STEALING_TASK_DEQUE_BANK_DEFINES_SVH

// Same-cycle implication, sampled on clk_i, disabled during reset.
`define WSD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i, disabled during reset.
`define WSD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/wsd_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_pkg
// Types, sizes and codes shared by the task deque bank modules.
// ----------------------------------------------------------------------------
package wsd_pkg;

  // Bank geometry
  localparam int NUM_QUEUES = 16;
  localparam int LOG_DEPTH  = 7;
  localparam int TASK_WIDTH = 32;

  localparam int QADDR_W  = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
  localparam int CNT_W    = LOG_DEPTH + 1;
  localparam int STORE_AW = QADDR_W + LOG_DEPTH;
  localparam int STORE_DEPTH = NUM_QUEUES * (1 << LOG_DEPTH);

  // Interface field widths
  localparam int OP_W       = 2;
  localparam int QIDX_W     = 4;
  localparam int TASK_IN_W  = 32;
  localparam int STATUS_W   = 2;
  localparam int TASK_OUT_W = 32;
  localparam int ACTQ_W     = 5;

  localparam int S_FIELDS_W = OP_W + QIDX_W + TASK_IN_W;
  localparam int M_FIELDS_W = STATUS_W + 1 + TASK_OUT_W;
  localparam int S_TDATA_W  = ((S_FIELDS_W + 7) / 8) * 8;
  localparam int M_TDATA_W  = ((M_FIELDS_W + 7) / 8) * 8;

  localparam logic [ACTQ_W-1:0] ACTQ_RESET = ACTQ_W'(1);

  typedef enum logic [OP_W-1:0] {
    OP_PUSH  = 2'd0,
    OP_TAKE  = 2'd1,
    OP_STEAL = 2'd2,
    OP_NOP   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2,
    ST_BADQ  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOKUP,
    S_FETCH,
    S_DELIVER
  } ctrl_state_e;

  typedef struct packed {
    op_e                   op;
    logic [QIDX_W-1:0]     qidx;
    logic [TASK_IN_W-1:0]  task_in;
  } req_t;

  typedef struct packed {
    status_e               status;
    logic                  task_valid;
    logic [TASK_OUT_W-1:0] task_out;
  } res_t;

  typedef struct packed {
    logic [CNT_W-1:0] top;
    logic [CNT_W-1:0] bottom;
  } ptr_t;

  typedef struct packed {
    logic               we;
    logic [QADDR_W-1:0] addr;
    ptr_t               data;
  } ptr_wr_t;

  typedef struct packed {
    logic               re;
    logic [QADDR_W-1:0] addr;
  } ptr_rd_t;

  typedef struct packed {
    logic                  we;
    logic [STORE_AW-1:0]   addr;
    logic [TASK_WIDTH-1:0] data;
  } st_wr_t;

  typedef struct packed {
    logic                re;
    logic [STORE_AW-1:0] addr;
  } st_rd_t;

endpackage

/* sv/wsd_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module wsd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

/* sv/wsd_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_ctrl
// Request sequencer: pointer read-modify-write and task store access.
// ----------------------------------------------------------------------------
module wsd_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      req_valid_i,
  output logic                      req_ready_o,
  input  wsd_pkg::req_t             req_i,
  input  logic [wsd_pkg::ACTQ_W-1:0] active_queues_i,
  output logic                      res_valid_o,
  input  logic                      res_ready_i,
  output wsd_pkg::res_t             res_o,
  output wsd_pkg::ptr_rd_t          ptr_rd_o,
  output wsd_pkg::ptr_wr_t          ptr_wr_o,
  input  wsd_pkg::ptr_t             ptr_rdata_i,
  output wsd_pkg::st_rd_t           st_rd_o,
  output wsd_pkg::st_wr_t           st_wr_o,
  input  logic [wsd_pkg::TASK_WIDTH-1:0] st_rdata_i
);

  wsd_pkg::ctrl_state_e state_q, state_d;
  wsd_pkg::req_t        req_q, req_d;
  wsd_pkg::status_e     res_status_q, res_status_d;
  logic                 res_tvalid_q, res_tvalid_d;
  logic [wsd_pkg::TASK_OUT_W-1:0] res_task_q, res_task_d;

  // Pointer entries count as zero until their first write.
  logic [wsd_pkg::NUM_QUEUES-1:0] ptr_vld_q;

  wsd_pkg::ptr_rd_t ptr_rd;
  wsd_pkg::ptr_wr_t ptr_wr;
  wsd_pkg::st_rd_t  st_rd;
  wsd_pkg::st_wr_t  st_wr;

  logic [wsd_pkg::QADDR_W-1:0] qa_q;
  wsd_pkg::ptr_t               ptr_cur;
  logic [wsd_pkg::CNT_W-1:0]   occ;
  logic [wsd_pkg::CNT_W-1:0]   bot_dec;
  logic                        bad_q;
  logic                        is_full;
  logic                        is_empty;

  assign qa_q     = wsd_pkg::QADDR_W'(req_q.qidx);
  assign ptr_cur  = ptr_vld_q[qa_q] ? ptr_rdata_i : '0;
  assign occ      = ptr_cur.bottom - ptr_cur.top;
  assign bot_dec  = ptr_cur.bottom - wsd_pkg::CNT_W'(1);
  assign is_full  = occ[wsd_pkg::CNT_W-1];
  assign is_empty = (occ == '0);
  assign bad_q    = ({{(32-wsd_pkg::ACTQ_W){1'b0}}, (wsd_pkg::ACTQ_W)'(req_q.qidx)}
                      >= {{(32-wsd_pkg::ACTQ_W){1'b0}}, active_queues_i})
                 || ({{(32-wsd_pkg::QIDX_W){1'b0}}, req_q.qidx} >= 32'(wsd_pkg::NUM_QUEUES));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= wsd_pkg::S_IDLE;
      ptr_vld_q <= '0;
    end else begin
      state_q <= state_d;
      if (ptr_wr.we) begin
        ptr_vld_q[ptr_wr.addr] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    req_q        <= req_d;
    res_status_q <= res_status_d;
    res_tvalid_q <= res_tvalid_d;
    res_task_q   <= res_task_d;
  end

  always_comb begin
    state_d      = state_q;
    req_d        = req_q;
    res_status_d = res_status_q;
    res_tvalid_d = res_tvalid_q;
    res_task_d   = res_task_q;
    ptr_rd       = '0;
    ptr_wr       = '0;
    st_rd        = '0;
    st_wr        = '0;
    req_ready_o  = 1'b0;
    res_valid_o  = 1'b0;

    case (state_q)
      wsd_pkg::S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          req_d       = req_i;
          ptr_rd.re   = 1'b1;
          ptr_rd.addr = wsd_pkg::QADDR_W'(req_i.qidx);
          state_d     = wsd_pkg::S_LOOKUP;
        end
      end

      wsd_pkg::S_LOOKUP: begin
        res_status_d = wsd_pkg::ST_OK;
        res_tvalid_d = 1'b0;
        res_task_d   = '0;
        ptr_wr.addr  = qa_q;
        ptr_wr.data  = ptr_cur;
        state_d      = wsd_pkg::S_DELIVER;
        if (bad_q) begin
          res_status_d = wsd_pkg::ST_BADQ;
        end else begin
          case (req_q.op)
            wsd_pkg::OP_PUSH: begin
              if (is_full) begin
                res_status_d = wsd_pkg::ST_FULL;
              end else begin
                st_wr.we    = 1'b1;
                st_wr.addr  = {qa_q, ptr_cur.bottom[wsd_pkg::LOG_DEPTH-1:0]};
                st_wr.data  = wsd_pkg::TASK_WIDTH'(req_q.task_in);
                ptr_wr.we   = 1'b1;
                ptr_wr.data.bottom = ptr_cur.bottom + wsd_pkg::CNT_W'(1);
              end
            end
            wsd_pkg::OP_TAKE: begin
              if (is_empty) begin
                res_status_d = wsd_pkg::ST_EMPTY;
              end else begin
                ptr_wr.we          = 1'b1;
                ptr_wr.data.bottom = bot_dec;
                st_rd.re           = 1'b1;
                st_rd.addr         = {qa_q, bot_dec[wsd_pkg::LOG_DEPTH-1:0]};
                res_tvalid_d       = 1'b1;
                state_d            = wsd_pkg::S_FETCH;
              end
            end
            wsd_pkg::OP_STEAL: begin
              if (is_empty) begin
                res_status_d = wsd_pkg::ST_EMPTY;
              end else begin
                ptr_wr.we       = 1'b1;
                ptr_wr.data.top = ptr_cur.top + wsd_pkg::CNT_W'(1);
                st_rd.re        = 1'b1;
                st_rd.addr      = {qa_q, ptr_cur.top[wsd_pkg::LOG_DEPTH-1:0]};
                res_tvalid_d    = 1'b1;
                state_d         = wsd_pkg::S_FETCH;
              end
            end
            wsd_pkg::OP_NOP: begin
              res_status_d = wsd_pkg::ST_OK;
            end
            default: begin
              res_status_d = wsd_pkg::ST_OK;
            end
          endcase
        end
      end

      wsd_pkg::S_FETCH: begin
        res_task_d = wsd_pkg::TASK_OUT_W'(st_rdata_i);
        state_d    = wsd_pkg::S_DELIVER;
      end

      wsd_pkg::S_DELIVER: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = wsd_pkg::S_IDLE;
        end
      end

      default: begin
        state_d = wsd_pkg::S_IDLE;
      end
    endcase
  end

  assign res_o    = '{status: res_status_q, task_valid: res_tvalid_q, task_out: res_task_q};
  assign ptr_rd_o = ptr_rd;
  assign ptr_wr_o = ptr_wr;
  assign st_rd_o  = st_rd;
  assign st_wr_o  = st_wr;

endmodule

/* sv/work_stealing_task_deque_bank.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// work_stealing_task_deque_bank
// Bank of per-worker task deques with push, take and steal requests.
// ----------------------------------------------------------------------------
// Requests enter on the s_axis channel, one result per request leaves on the
// m_axis channel. Push appends at the bottom, take pops the bottom, steal pops
// the top; status reports ok, empty, full or an inactive queue index.
// Requests are served one at a time. Between acceptance and a valid result lie
// the pointer RAM read, the pointer write-back and the output register, with a
// task store read added for take and steal. s_axis_tready is high only while
// the sequencer is idle, so a new request waits until the last result has moved
// to the output register. The output register holds a finished result while
// the receiver stalls; the next request is still accepted and waits for the
// register to drain. Reset clears the sequencer, the output register and the
// pointer valid bits, so every queue reads empty at once; no clearing pass runs.
// active_queues resets to one and is written through cfg_we_i / cfg_wdata_i;
// the user must write it only while idle; the block does not enforce this.
// ----------------------------------------------------------------------------
module work_stealing_task_deque_bank (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [wsd_pkg::ACTQ_W-1:0]       cfg_wdata_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  // [1:0] opcode, [5:2] queue_index, [37:6] task_in, rest zero
  input  logic [wsd_pkg::S_TDATA_W-1:0]    s_axis_tdata,
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  // [1:0] status, [2] task_valid, [34:3] task_out, rest zero
  output logic [wsd_pkg::M_TDATA_W-1:0]    m_axis_tdata
);

  logic [wsd_pkg::ACTQ_W-1:0] active_queues_q;

  wsd_pkg::req_t    req;
  wsd_pkg::res_t    res;
  logic             res_valid;
  logic             res_ready;
  wsd_pkg::ptr_rd_t ptr_rd;
  wsd_pkg::ptr_wr_t ptr_wr;
  wsd_pkg::ptr_t    ptr_rdata;
  logic [$bits(wsd_pkg::ptr_t)-1:0] ptr_rdata_raw;
  wsd_pkg::st_rd_t  st_rd;
  wsd_pkg::st_wr_t  st_wr;
  logic [wsd_pkg::TASK_WIDTH-1:0] st_rdata;

  logic                          out_valid_q, out_valid_d;
  logic [wsd_pkg::M_TDATA_W-1:0] out_data_q, out_data_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_queues_q <= wsd_pkg::ACTQ_RESET;
    end else if (cfg_we_i) begin
      active_queues_q <= cfg_wdata_i;
    end
  end

  assign req.op      = wsd_pkg::op_e'(s_axis_tdata[wsd_pkg::OP_W-1:0]);
  assign req.qidx    = s_axis_tdata[wsd_pkg::OP_W +: wsd_pkg::QIDX_W];
  assign req.task_in = s_axis_tdata[wsd_pkg::OP_W + wsd_pkg::QIDX_W +: wsd_pkg::TASK_IN_W];

  wsd_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .req_valid_i    (s_axis_tvalid),
    .req_ready_o    (s_axis_tready),
    .req_i          (req),
    .active_queues_i(active_queues_q),
    .res_valid_o    (res_valid),
    .res_ready_i    (res_ready),
    .res_o          (res),
    .ptr_rd_o       (ptr_rd),
    .ptr_wr_o       (ptr_wr),
    .ptr_rdata_i    (ptr_rdata),
    .st_rd_o        (st_rd),
    .st_wr_o        (st_wr),
    .st_rdata_i     (st_rdata)
  );

  wsd_ram #(
    .WIDTH($bits(wsd_pkg::ptr_t)),
    .DEPTH(wsd_pkg::NUM_QUEUES),
    .AW   (wsd_pkg::QADDR_W)
  ) u_ptr_ram (
    .clk_i  (clk_i),
    .we_i   (ptr_wr.we),
    .waddr_i(ptr_wr.addr),
    .wdata_i(ptr_wr.data),
    .re_i   (ptr_rd.re),
    .raddr_i(ptr_rd.addr),
    .rdata_o(ptr_rdata_raw)
  );

  assign ptr_rdata = ptr_rdata_raw;

  wsd_ram #(
    .WIDTH(wsd_pkg::TASK_WIDTH),
    .DEPTH(wsd_pkg::STORE_DEPTH),
    .AW   (wsd_pkg::STORE_AW)
  ) u_task_ram (
    .clk_i  (clk_i),
    .we_i   (st_wr.we),
    .waddr_i(st_wr.addr),
    .wdata_i(st_wr.data),
    .re_i   (st_rd.re),
    .raddr_i(st_rd.addr),
    .rdata_o(st_rdata)
  );

  // Load a new result whenever the output register is empty or draining.
  assign res_ready = !out_valid_q || m_axis_tready;

  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    if (res_valid && res_ready) begin
      out_valid_d = 1'b1;
      out_data_d  = wsd_pkg::M_TDATA_W'({res.task_out, res.task_valid, res.status});
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q <= out_data_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;

endmodule

/* sv/wsd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wsd_checker
// Port-level checks on the task deque bank, bound to the top level.
// ----------------------------------------------------------------------------
`include "work_stealing_task_deque_bank_defines.svh"

module wsd_checker (
  input logic                          clk_i,
  input logic                          rst_ni,
  input logic                          s_axis_tvalid,
  input logic                          s_axis_tready,
  input logic                          m_axis_tvalid,
  input logic                          m_axis_tready,
  input logic [wsd_pkg::M_TDATA_W-1:0] m_axis_tdata
);

  // A stalled result holds until taken.
  `WSD_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "result changed while stalled")

  // Only one request is in flight: no accept right after an accept.
  `WSD_ASSERT_NEXT(a_one_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready, "request accepted while busy")

  // A removed task always comes with status ok.
  `WSD_ASSERT_NOW(a_task_ok, m_axis_tvalid && m_axis_tdata[2], m_axis_tdata[1:0] == wsd_pkg::ST_OK, "task returned with error status")

  // No task means a zero handle.
  `WSD_ASSERT_NOW(a_task_zero, m_axis_tvalid && !m_axis_tdata[2], m_axis_tdata[34:3] == 32'd0, "nonzero handle without task")

endmodule

bind work_stealing_task_deque_bank wsd_checker u_wsd_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .s_axis_tvalid(s_axis_tvalid),
  .s_axis_tready(s_axis_tready),
  .m_axis_tvalid(m_axis_tvalid),
  .m_axis_tready(m_axis_tready),
  .m_axis_tdata (m_axis_tdata)
);
